// ----- rtl/core/kltw_pkg.sv -----
// kltw_pkg: constants, types and lookup functions for the keypad to lcd text writer
// used by kltw_plan and keypad_to_lcd_text_writer; no dependencies
package kltw_pkg;

	localparam int unsigned CountW   = 7;
	localparam int unsigned IdxW     = 3;
	localparam int unsigned SetupLen = 5;
	localparam int unsigned RowLen   = 20;
	localparam int unsigned ScreenLen = 80;

	// item kinds
	localparam logic KIND_INIT = 1'b0;
	localparam logic KIND_KEY  = 1'b1;

	// line address instructions
	localparam logic [7:0] LINE2_ADDR = 8'hC0;
	localparam logic [7:0] LINE3_ADDR = 8'h94;
	localparam logic [7:0] LINE4_ADDR = 8'hD4;

	// first byte of the set-up sequence
	localparam logic [7:0] SETUP_FUNC = 8'h38;

	// compact description of the results caused by one item
	typedef struct packed {
		logic             setup;     // header is the set-up sequence
		logic             wrap;      // header is one line address instruction
		logic [7:0]       wrap_byte;
		logic             has_data;
		logic [7:0]       data_byte;
		logic [IdxW-1:0]  total;     // number of results, zero to six
	} burst_t;

	// set-up sequence byte by position
	function automatic logic [7:0] setup_byte(input logic [IdxW-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = SETUP_FUNC;
			3'd1:    b = 8'h08;
			3'd2:    b = 8'h01;
			3'd3:    b = 8'h06;
			3'd4:    b = 8'h0E;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// keypad code to ascii, zero marks an unmapped code
	function automatic logic [7:0] key_char(input logic [3:0] code);
		logic [7:0] c;
		unique case (code)
			4'h0:    c = 8'h31;
			4'h1:    c = 8'h32;
			4'h2:    c = 8'h33;
			4'h4:    c = 8'h34;
			4'h5:    c = 8'h35;
			4'h6:    c = 8'h36;
			4'h8:    c = 8'h37;
			4'h9:    c = 8'h38;
			4'hA:    c = 8'h39;
			4'hC:    c = 8'h2A;
			4'hD:    c = 8'h30;
			4'hE:    c = 8'h23;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/keypad_to_lcd_text_writer.sv -----
// keypad_to_lcd_text_writer: 20x4 character display writer fed by keypad codes
// depends on kltw_pkg and kltw_plan
// the first result of an item is valid in the cycle after it is accepted
// throughput: one result per cycle while out_stall is low; an item holds the
// result register until its last result is taken, one giving none never does
// reset: character count cleared, no result pending
module keypad_to_lcd_text_writer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [3:0] key_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] lcd_byte,
	output logic       is_data,
	output logic       last
);

	logic [kltw_pkg::CountW-1:0] char_count_q;
	logic [kltw_pkg::CountW-1:0] count_next;
	logic                        busy_q;
	logic [kltw_pkg::IdxW-1:0]   idx_q;
	kltw_pkg::burst_t            burst_q;
	kltw_pkg::burst_t            plan;
	logic [kltw_pkg::IdxW-1:0]   hdr_len;
	logic                        in_take;
	logic                        out_take;

	kltw_plan u_plan (
		.kind       (kind),
		.key_code   (key_code),
		.count      (char_count_q),
		.plan       (plan),
		.count_next (count_next)
	);

	// result selection from the pending burst
	always_comb begin
		hdr_len = burst_q.setup ? kltw_pkg::IdxW'(kltw_pkg::SetupLen)
				: (burst_q.wrap ? kltw_pkg::IdxW'(1) : '0);
		if (idx_q < hdr_len) begin
			lcd_byte = burst_q.setup ? kltw_pkg::setup_byte(idx_q) : burst_q.wrap_byte;
			is_data  = 1'b0;
		end else begin
			lcd_byte = burst_q.data_byte;
			is_data  = 1'b1;
		end
		last = (idx_q == burst_q.total - kltw_pkg::IdxW'(1));
	end

	// handshakes: a new item enters as the final result leaves
	assign out_valid = busy_q;
	assign out_take  = busy_q && !out_stall;
	assign in_stall  = busy_q && !(out_take && last);
	assign in_take   = in_valid && !in_stall;

	// count state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
		end else if (in_take) begin
			char_count_q <= count_next;
		end
	end

	// result register and position within the burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_take) begin
			busy_q <= (plan.total != '0);
			idx_q  <= '0;
		end else if (out_take) begin
			if (last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + kltw_pkg::IdxW'(1);
		end
	end

	// burst payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			burst_q <= plan;
		end
	end

	// checks
	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_init_starts_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && kind == kltw_pkg::KIND_INIT) |=>
		(out_valid && !is_data && lcd_byte == kltw_pkg::SETUP_FUNC))
		else $error("initialize did not start the set-up sequence");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		char_count_q <= kltw_pkg::CountW'(kltw_pkg::ScreenLen))
		else $error("character count beyond the screen");

	a_data_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_data) |-> last)
		else $error("data byte not the final result of its transaction");

endmodule

// ----- rtl/core/kltw_plan.sv -----
// kltw_plan: works out the results and the next character count for one item
// depends on kltw_pkg
module kltw_plan (
	input  logic                        kind,
	input  logic [3:0]                  key_code,
	input  logic [kltw_pkg::CountW-1:0] count,
	output kltw_pkg::burst_t            plan,
	output logic [kltw_pkg::CountW-1:0] count_next
);

	logic [7:0]                  ch;
	logic                        full;
	logic [kltw_pkg::CountW-1:0] base;
	logic [kltw_pkg::IdxW-1:0]   hdr_len;

	// header choice, character lookup and count update
	always_comb begin
		ch   = kltw_pkg::key_char(key_code);
		full = (count >= kltw_pkg::CountW'(kltw_pkg::ScreenLen));
		plan = '0;
		base = count;
		if (kind == kltw_pkg::KIND_INIT) begin
			plan.setup = 1'b1;
			count_next = '0;
		end else begin
			if (count == kltw_pkg::CountW'(kltw_pkg::RowLen)) begin
				plan.wrap      = 1'b1;
				plan.wrap_byte = kltw_pkg::LINE2_ADDR;
			end else if (count == kltw_pkg::CountW'(2 * kltw_pkg::RowLen)) begin
				plan.wrap      = 1'b1;
				plan.wrap_byte = kltw_pkg::LINE3_ADDR;
			end else if (count == kltw_pkg::CountW'(3 * kltw_pkg::RowLen)) begin
				plan.wrap      = 1'b1;
				plan.wrap_byte = kltw_pkg::LINE4_ADDR;
			end else if (full) begin
				plan.setup = 1'b1;
				base       = '0;
			end
			plan.has_data  = (ch != 8'h00);
			plan.data_byte = ch;
			count_next     = base + kltw_pkg::CountW'(1);
		end
		hdr_len = plan.setup ? kltw_pkg::IdxW'(kltw_pkg::SetupLen)
				: (plan.wrap ? kltw_pkg::IdxW'(1) : '0);
		plan.total = hdr_len + kltw_pkg::IdxW'(plan.has_data);
	end

endmodule

// ----- dv/keypad_to_lcd_text_writer_tb.sv -----
// keypad_to_lcd_text_writer_tb: self-checking bench for the keypad to 20x4 display writer
// depends on kltw_pkg and the keypad_to_lcd_text_writer rtl; needs no files or arguments
module keypad_to_lcd_text_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kltw_pkg::*;

	// one write on the display bus
	typedef struct packed {
		logic [7:0] lcd_byte;
		logic       is_data;
		logic       last;
	} lcd_write_t;

	// set-up instructions, entry 0 goes out first
	localparam logic [4:0][7:0] SETUP_SEQ = {8'h0E, 8'h06, 8'h01, 8'h08, SETUP_FUNC};
	// keypad glyphs, zero for the four unused codes
	localparam logic [15:0][7:0] KEY_GLYPH = {
		8'h00, "#", "0", "*",
		8'h00, "9", "8", "7",
		8'h00, "6", "5", "4",
		8'h00, "3", "2", "1"
	};
	localparam logic [3:0] CODE_UNUSED = 4'h3;
	localparam int unsigned HOLD_CYCLES = 300;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       kind;
	logic [3:0] key_code;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] lcd_byte;
	logic       is_data;
	logic       last;

	// predictor state and expected display writes
	logic [CountW-1:0] chars_on_screen;
	lcd_write_t        pending_writes[$];

	int send_idle_pct;
	int stall_pct;
	bit hold_request;
	int fault_count;
	int key_items;
	int init_items;
	int writes_checked;
	int wraps_seen;
	int refills_seen;

	keypad_to_lcd_text_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.key_code  (key_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.lcd_byte  (lcd_byte),
		.is_data   (is_data),
		.last      (last)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// queue the five set-up instructions
	function automatic void queue_setup();
		for (int i = 0; i < SetupLen; i++)
			pending_writes.push_back('{SETUP_SEQ[i], 1'b0, 1'b0});
	endfunction

	// work out the display writes caused by one accepted transaction
	function automatic void predict_display_writes(input logic k, input logic [3:0] code);
		int depth_before;
		depth_before = pending_writes.size();
		if (k == KIND_INIT) begin
			queue_setup();
			chars_on_screen = '0;
			init_items++;
		end else begin
			key_items++;
			if (chars_on_screen == RowLen) begin
				pending_writes.push_back('{LINE2_ADDR, 1'b0, 1'b0});
				wraps_seen++;
			end else if (chars_on_screen == 2 * RowLen) begin
				pending_writes.push_back('{LINE3_ADDR, 1'b0, 1'b0});
				wraps_seen++;
			end else if (chars_on_screen == 3 * RowLen) begin
				pending_writes.push_back('{LINE4_ADDR, 1'b0, 1'b0});
				wraps_seen++;
			end else if (chars_on_screen >= ScreenLen) begin
				queue_setup();
				chars_on_screen = '0;
				refills_seen++;
			end
			if (KEY_GLYPH[code] != 8'h00)
				pending_writes.push_back('{KEY_GLYPH[code], 1'b1, 1'b0});
			chars_on_screen = chars_on_screen + 1'b1;
		end
		// final write of the transaction carries last
		if (pending_writes.size() > depth_before)
			pending_writes[pending_writes.size() - 1].last = 1'b1;
	endfunction

	// offer one item, starting and ending at a falling edge
	task automatic send_item(input logic k, input logic [3:0] code);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			kind     <= 1'($urandom_range(1));
			key_code <= 4'($urandom_range(15));
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		key_code <= code;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predict_display_writes(k, code);
		@(negedge clk);
	endtask

	task automatic send_key(input logic [3:0] code);
		send_item(KIND_KEY, code);
	endtask

	// receiver stall, with an optional long hold-off counted here
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// compare each accepted display write with the oldest expectation
	always @(posedge clk) begin
		lcd_write_t seen;
		lcd_write_t wanted;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			seen = '{lcd_byte, is_data, last};
			writes_checked++;
			if (pending_writes.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: unexpected write byte %h data %b last %b",
						$realtime, seen.lcd_byte, seen.is_data, seen.last);
			end else begin
				wanted = pending_writes.pop_front();
				if (seen !== wanted) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: expected %h/%b/%b, got %h/%b/%b",
							$realtime, wanted.lcd_byte, wanted.is_data, wanted.last,
							seen.lcd_byte, seen.is_data, seen.last);
				end
			end
		end
	end

	// initialize with two different values of the ignored key code
	task automatic test_initialize();
		send_item(KIND_INIT, 4'hF);
		send_item(KIND_INIT, 4'h0);
	endtask

	// every key code once, mapped and unused, from a cleared screen
	task automatic test_key_map();
		for (int c = 0; c < 16; c++)
			send_key(c[3:0]);
	endtask

	// fill the first line, then an unused key alone at the wrap, then a glyph
	task automatic test_line_wrap();
		while (chars_on_screen < RowLen)
			send_key(4'h5);
		send_key(CODE_UNUSED);
		send_key(4'hD);
	endtask

	// random keys with rare initialize commands under one idling setting
	task automatic test_random_traffic(input int items, input int sender_idle,
			input int stall_rate, input int init_per_mille);
		send_idle_pct = sender_idle;
		stall_pct     = stall_rate;
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(999) < init_per_mille)
				send_item(KIND_INIT, 4'($urandom_range(15)));
			else
				send_key(4'($urandom_range(15)));
		end
	endtask

	// long receiver hold-off while keys keep coming, so the input stalls
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_request  = 1'b1;
		for (int i = 0; i < 20; i++)
			send_key(4'($urandom_range(15)));
	endtask

	// stimulus
	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		kind            = KIND_INIT;
		key_code        = 4'h0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		hold_request    = 1'b0;
		chars_on_screen = '0;
		fault_count     = 0;
		key_items       = 0;
		init_items      = 0;
		writes_checked  = 0;
		wraps_seen      = 0;
		refills_seen    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_initialize();
		test_key_map();
		test_line_wrap();
		test_random_traffic(70, 0, 0, 0);
		test_random_traffic(35, 80, 0, 20);
		test_random_traffic(35, 0, 80, 20);
		test_backpressure();
		test_random_traffic(35, 35, 35, 20);

		in_valid <= 1'b0;
		stall_pct = 0;
		wait (pending_writes.size() == 0);
		repeat (10) @(posedge clk);

		$display("covered %0d key and %0d initialize transactions, %0d display writes checked",
			key_items, init_items, writes_checked);
		$display("line wraps %0d, full screen refills %0d, one long receiver hold-off",
			wraps_seen, refills_seen);
		if (fault_count == 0 && pending_writes.size() == 0) begin
			$display("PASS keypad_to_lcd_text_writer");
		end else begin
			$display("%0d mismatches, %0d writes still expected", fault_count,
				pending_writes.size());
			$display("FAIL keypad_to_lcd_text_writer");
		end
		$finish;
	end

	// run limit
	initial begin
		#400us;
		$display("timeout with %0d writes still expected", pending_writes.size());
		$display("FAIL keypad_to_lcd_text_writer");
		$finish;
	end

endmodule
